/* rtl/core/ofb_byte_stream_cipher_assert.svh */
// ----------------------------------------------------------------------------
// OFB byte stream cipher: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef OFB_BYTE_STREAM_CIPHER_ASSERT_SVH
`define OFB_BYTE_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication
`define OFB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ofb_pkg.sv */
// ----------------------------------------------------------------------------
// OFB byte stream cipher: shared package
// Types, opcodes, register indexes and the chaining block wiring table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofb_pkg;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_IDX_W   = 2;

    // opcodes
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_RELOAD = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd3;

    // position value that means the keystream is used up
    localparam logic [POS_W-1:0] POS_EMPTY = 5'd16;

    typedef logic [BLOCK_BYTES-1:0][7:0] t_block;

    typedef struct packed {
        logic [CFG_W-1:0] key_low;
        logic [CFG_W-1:0] key_high;
        logic [CFG_W-1:0] iv_low;
        logic [CFG_W-1:0] iv_high;
    } t_cfg_regs;

    typedef struct packed {
        logic [3:0] dest;
        logic [3:0] src0;
        logic [3:0] src1;
        logic [3:0] src2;
        logic       three;
        logic [3:0] key_sel;
    } t_wire_row;

    // wiring of one new chaining byte: destination, sources, key byte
    function automatic t_wire_row wire_row(input logic [3:0] r);
        t_wire_row w;
        w = '0;
        case (r)
            4'd0:    w = '{4'd15, 4'd3,  4'd6,  4'd0,  1'b0, 4'd4};
            4'd1:    w = '{4'd14, 4'd13, 4'd10, 4'd0,  1'b0, 4'd2};
            4'd2:    w = '{4'd13, 4'd9,  4'd1,  4'd0,  1'b0, 4'd13};
            4'd3:    w = '{4'd12, 4'd10, 4'd14, 4'd0,  1'b0, 4'd7};
            4'd4:    w = '{4'd11, 4'd12, 4'd5,  4'd0,  1'b0, 4'd15};
            4'd5:    w = '{4'd10, 4'd0,  4'd2,  4'd0,  1'b0, 4'd1};
            4'd6:    w = '{4'd9,  4'd3,  4'd6,  4'd0,  1'b0, 4'd14};
            4'd7:    w = '{4'd8,  4'd0,  4'd13, 4'd0,  1'b0, 4'd6};
            4'd8:    w = '{4'd7,  4'd8,  4'd5,  4'd0,  1'b0, 4'd12};
            4'd9:    w = '{4'd6,  4'd3,  4'd10, 4'd0,  1'b0, 4'd0};
            4'd10:   w = '{4'd5,  4'd2,  4'd9,  4'd0,  1'b0, 4'd3};
            4'd11:   w = '{4'd4,  4'd3,  4'd11, 4'd0,  1'b0, 4'd11};
            4'd12:   w = '{4'd3,  4'd1,  4'd14, 4'd0,  1'b0, 4'd5};
            4'd13:   w = '{4'd2,  4'd7,  4'd15, 4'd0,  1'b0, 4'd10};
            4'd14:   w = '{4'd1,  4'd2,  4'd5,  4'd0,  1'b0, 4'd8};
            4'd15:   w = '{4'd0,  4'd0,  4'd4,  4'd10, 1'b1, 4'd9};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ofb_byte_stream_cipher.sv */
// ----------------------------------------------------------------------------
// OFB byte stream cipher: top level
// Byte-wide output feedback mode encrypt/decrypt with key and IV registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: i_opcode
//   and i_data_byte. A data request yields one o_out_byte on the output
//   channel (o_out_valid / i_out_stall); a reload request yields nothing.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set key and IV;
//   write them only while no request is in flight.
//   A request taken sits in the input register; a data result is registered
//   in the result register once the output is free, raising o_out_valid.
//   Throughput: one request per cycle while the output is not stalled,
//   set by the update of the chaining block and byte position registers.
//   When the receiver stalls, the result register holds; the input register
//   keeps one more request and then o_in_stall rises. Reload requests pass
//   the input register even while the output is stalled.
//   Reset clears key, IV and chaining block to zero and marks the keystream
//   used up, so the first data byte forms a fresh block from the zero chaining block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofb_byte_stream_cipher (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_stall,
    input  wire logic                           i_opcode,
    input  wire logic [7:0]                     i_data_byte,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    output      logic [7:0]                     o_out_byte,
    input  wire logic                           i_cfg_we,
    input  wire logic [ofb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ofb_pkg::CFG_W-1:0]      i_cfg_data
);
    import ofb_pkg::*;

    t_cfg_regs        cfg;
    t_block           key_block;
    t_block           iv_block;
    t_block           fresh;

    logic             r_s1_valid;
    logic             r_s1_opcode;
    logic [7:0]       r_s1_data;

    t_block           r_chain;
    t_block           n_chain;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       n_out_byte;

    logic             in_accept;
    logic             out_free;
    logic             s1_fire;
    logic             s1_data_fire;
    logic [7:0]       ks_byte;

    ofb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (cfg)
    );

    assign key_block = {cfg.key_high, cfg.key_low};
    assign iv_block  = {cfg.iv_high, cfg.iv_low};

    ofb_block_gen u_gen (
        .i_chain (r_chain),
        .i_key   (key_block),
        .o_fresh (fresh)
    );

    // handshake
    assign out_free     = !r_out_valid || !i_out_stall;
    assign s1_fire      = r_s1_valid && (r_s1_opcode == OP_RELOAD || out_free);
    assign s1_data_fire = s1_fire && r_s1_opcode == OP_DATA;
    assign o_in_stall   = r_s1_valid && !s1_fire;
    assign in_accept    = i_in_valid && !o_in_stall;

    // keystream byte and next state
    always_comb begin
        n_chain    = r_chain;
        n_pos      = r_pos;
        ks_byte    = r_chain[r_pos[3:0]];
        if (r_s1_opcode == OP_RELOAD) begin
            n_chain = iv_block;
            n_pos   = POS_EMPTY;
        end else if (r_pos[4]) begin
            // keystream used up: advance to a fresh block
            n_chain = fresh;
            ks_byte = fresh[0];
            n_pos   = POS_W'(1);
        end else begin
            n_pos   = r_pos + POS_W'(1);
        end
        n_out_byte = r_s1_data ^ ks_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_opcode <= i_opcode;
            r_s1_data   <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
            r_pos   <= POS_EMPTY;
        end else if (s1_fire) begin
            r_chain <= n_chain;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_data_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_data_fire) begin
            r_out_byte <= n_out_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

`include "ofb_byte_stream_cipher_assert.svh"

    `OFB_ASSERT_IMPLY(a_pos_range, 1'b1, r_pos <= POS_EMPTY, "byte position out of range")
    `OFB_ASSERT_NEXT(a_reload_pos, s1_fire && r_s1_opcode == OP_RELOAD, r_pos == POS_EMPTY, "reload did not mark keystream used up")
    `OFB_ASSERT_NEXT(a_fresh_pos, s1_data_fire && r_pos[4], r_pos == POS_W'(1), "fresh block did not restart position")
    `OFB_ASSERT_NEXT(a_data_result, s1_data_fire, r_out_valid, "data request produced no result")
    `OFB_ASSERT_IMPLY(a_stall_src, o_in_stall, r_s1_valid && r_s1_opcode == OP_DATA && r_out_valid, "input stall without blocked data request")

endmodule

`default_nettype wire

/* rtl/core/ofb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// OFB byte stream cipher: configuration registers
// Key and IV registers behind a plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofb_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ofb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ofb_pkg::CFG_W-1:0]      i_cfg_data,
    output ofb_pkg::t_cfg_regs                  o_regs
);
    import ofb_pkg::*;

    t_cfg_regs r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_regs.key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_regs.key_high <= i_cfg_data;
                CFG_IV_LOW:   r_regs.iv_low   <= i_cfg_data;
                CFG_IV_HIGH:  r_regs.iv_high  <= i_cfg_data;
                default: begin
                    r_regs <= r_regs;
                end
            endcase
        end
    end

    assign o_regs = r_regs;

endmodule

`default_nettype wire

/* rtl/core/ofb_block_gen.sv */
// ----------------------------------------------------------------------------
// OFB byte stream cipher: block generator
// Forms the next chaining block from the current one and the key in one
// flat XOR network.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofb_block_gen (
    input  wire ofb_pkg::t_block i_chain,
    input  wire ofb_pkg::t_block i_key,
    output ofb_pkg::t_block      o_fresh
);
    import ofb_pkg::*;

    always_comb begin
        t_wire_row  w;
        logic [7:0] acc;
        o_fresh = '0;
        for (int r = 0; r < BLOCK_BYTES; r++) begin
            w   = wire_row(4'(r));
            acc = i_chain[w.src0] ^ i_chain[w.src1] ^ i_key[w.key_sel];
            if (w.three) begin
                acc = acc ^ i_chain[w.src2];
            end
            o_fresh[w.dest] = ~acc;
        end
    end

endmodule

`default_nettype wire
